@@ src/cgmb_pkg.sv @@
// ----------------------------------------------------------------------------
// Code granule mark bitmap package
// Shared types, constants and operation codes.
// ----------------------------------------------------------------------------
package cgmb_pkg;

	localparam int unsigned ADDR_BITS_DEF  = 20;
	localparam int unsigned GRAN_SHIFT_DEF = 2;
	localparam int unsigned MAX_LEN_DEF    = 4096;
	localparam int unsigned LEN_W          = 13;
	localparam int unsigned OP_W           = 2;
	localparam int unsigned WORD_W         = 64;
	localparam int unsigned BIT_IDX_W      = 6;

	typedef enum logic [OP_W-1:0] {
		OP_MARK    = 2'd0,
		OP_UNMARK  = 2'd1,
		OP_ANY     = 2'd2,
		OP_ALL     = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_WAIT,
		ST_WRITE,
		ST_DONE
	} bk_state_t;

endpackage

@@ src/code_granule_mark_bitmap_unit.sv @@
// ----------------------------------------------------------------------------
// Code granule mark bitmap unit
// Marks, unmarks and queries granule ranges in a bitmap of 64-bit words.
//
//   Channel  Signals                        Direction
//   in       in_valid in_stall op addr len  request
//   out      out_valid out_stall hit        result
//            overlap_error
//
// A request walks the bitmap words its range touches (1 to 17 at default
// settings) through read, wait and write states; an empty range skips the
// walk. The single RAM port pair paces the read-modify-write walk. After
// reset a clearing pass over all 2^(ADDR_BITS-GRAN_SHIFT-6) words (4096 at
// default settings) runs before the first request is processed; the front
// queue still accepts two requests. A stalled result holds the back end.
// ----------------------------------------------------------------------------
module code_granule_mark_bitmap_unit #(
	parameter int unsigned ADDR_BITS  = cgmb_pkg::ADDR_BITS_DEF,
	parameter int unsigned GRAN_SHIFT = cgmb_pkg::GRAN_SHIFT_DEF,
	parameter int unsigned MAX_LEN    = cgmb_pkg::MAX_LEN_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [cgmb_pkg::OP_W-1:0]  op,
	input  logic [ADDR_BITS-1:0]       addr,
	input  logic [cgmb_pkg::LEN_W-1:0] len,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       hit,
	output logic                       overlap_error
);

	localparam int unsigned GB = ADDR_BITS - GRAN_SHIFT;

	logic          q_valid, q_pop, q_empty_range;
	cgmb_pkg::op_t q_op;
	logic [GB-1:0] q_first, q_last;

	cgmb_front #(.ADDR_BITS(ADDR_BITS), .GRAN_SHIFT(GRAN_SHIFT), .MAX_LEN(MAX_LEN)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .op, .addr, .len,
		.q_valid, .q_pop, .q_op, .q_first, .q_last, .q_empty_range
	);

	cgmb_back #(.ADDR_BITS(ADDR_BITS), .GRAN_SHIFT(GRAN_SHIFT)) u_back (
		.clk, .arst_n, .q_valid, .q_pop, .q_op, .q_first, .q_last, .q_empty_range,
		.out_valid, .out_stall, .hit, .overlap_error
	);

endmodule

@@ src/cgmb_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cgmb_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ src/cgmb_front.sv @@
// ----------------------------------------------------------------------------
// Code granule mark bitmap front end
// Accepts requests, saturates the length and computes the granule range
// into a two-entry queue.
// ----------------------------------------------------------------------------
module cgmb_front #(
	parameter int unsigned ADDR_BITS  = cgmb_pkg::ADDR_BITS_DEF,
	parameter int unsigned GRAN_SHIFT = cgmb_pkg::GRAN_SHIFT_DEF,
	parameter int unsigned MAX_LEN    = cgmb_pkg::MAX_LEN_DEF,
	localparam int unsigned GB        = ADDR_BITS - GRAN_SHIFT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [cgmb_pkg::OP_W-1:0]   op,
	input  logic [ADDR_BITS-1:0]        addr,
	input  logic [cgmb_pkg::LEN_W-1:0]  len,
	output logic                        q_valid,
	input  logic                        q_pop,
	output cgmb_pkg::op_t               q_op,
	output logic [GB-1:0]               q_first,
	output logic [GB-1:0]               q_last,
	output logic                        q_empty_range
);

	localparam int unsigned LW = (cgmb_pkg::LEN_W > $clog2(MAX_LEN + 1)) ?
		cgmb_pkg::LEN_W : $clog2(MAX_LEN + 1);

	cgmb_pkg::op_t   op_q    [2];
	logic [GB-1:0]   first_q [2];
	logic [GB-1:0]   last_q  [2];
	logic            empty_q [2];
	logic            wp_q, rp_q;
	logic [1:0]      cnt_q;

	logic [LW-1:0]        len_x, len_s;
	logic [ADDR_BITS-1:0] end_a;
	logic                 push;

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;

	always_comb begin
		len_x = LW'(len);
		len_s = (len_x > LW'(MAX_LEN)) ? LW'(MAX_LEN) : len_x;
		end_a = addr + ADDR_BITS'(len_s) - ADDR_BITS'(1);
	end

	always_ff @(posedge clk) begin
		if (push) begin
			op_q[wp_q]    <= cgmb_pkg::op_t'(op);
			first_q[wp_q] <= addr[ADDR_BITS-1:GRAN_SHIFT];
			last_q[wp_q]  <= end_a[ADDR_BITS-1:GRAN_SHIFT];
			empty_q[wp_q] <= (len_s == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (q_pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

	assign q_valid       = (cnt_q != 2'd0);
	assign q_op          = op_q[rp_q];
	assign q_first       = first_q[rp_q];
	assign q_last        = last_q[rp_q];
	assign q_empty_range = empty_q[rp_q];

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(cnt_q == 2'd2 && push)) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("queue underflow");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("bad queue count");
`endif

endmodule

@@ src/cgmb_back.sv @@
// ----------------------------------------------------------------------------
// Code granule mark bitmap back end
// Clears the bitmap after reset, then walks each range one word at a time
// with read, modify and write, and holds the result in an output register.
// ----------------------------------------------------------------------------
module cgmb_back #(
	parameter int unsigned ADDR_BITS  = cgmb_pkg::ADDR_BITS_DEF,
	parameter int unsigned GRAN_SHIFT = cgmb_pkg::GRAN_SHIFT_DEF,
	localparam int unsigned GB        = ADDR_BITS - GRAN_SHIFT,
	localparam int unsigned WB        = GB - cgmb_pkg::BIT_IDX_W,
	localparam int unsigned DEPTH     = 1 << WB
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	output logic               q_pop,
	input  cgmb_pkg::op_t      q_op,
	input  logic [GB-1:0]      q_first,
	input  logic [GB-1:0]      q_last,
	input  logic               q_empty_range,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               hit,
	output logic               overlap_error
);

	localparam int unsigned BW = cgmb_pkg::BIT_IDX_W;
	localparam int unsigned W  = cgmb_pkg::WORD_W;

	cgmb_pkg::bk_state_t state_q, state_nx;
	logic [WB-1:0] wcur_q, wlast_q;
	logic [BW-1:0] blo_q, bhi_q;
	logic          first_word_q;
	logic          any_q, all_q;
	cgmb_pkg::op_t op_q;
	logic          ovalid_q, hit_q, oerr_q;

	logic          ram_we;
	logic [WB-1:0] ram_waddr, ram_raddr;
	logic [W-1:0]  ram_wdata, ram_rdata;
	logic [W-1:0]  mask;
	logic          can_out;

	cgmb_ram #(.WIDTH(W), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign can_out   = !ovalid_q || !out_stall;

	always_comb begin
		logic [W-1:0] lo_m, hi_m;
		lo_m = ~'0 << (first_word_q ? blo_q : BW'(0));
		hi_m = ~'0 >> (W - 1 - ((wcur_q == wlast_q) ? 32'(bhi_q) : (W - 1)));
		mask = lo_m & hi_m;
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			cgmb_pkg::ST_CLEAR: if (wcur_q == WB'(DEPTH - 1)) state_nx = cgmb_pkg::ST_IDLE;
			cgmb_pkg::ST_IDLE: begin
				if (q_valid) begin
					state_nx = q_empty_range ? cgmb_pkg::ST_DONE : cgmb_pkg::ST_READ;
				end
			end
			cgmb_pkg::ST_READ:  state_nx = cgmb_pkg::ST_WAIT;
			cgmb_pkg::ST_WAIT:  state_nx = cgmb_pkg::ST_WRITE;
			cgmb_pkg::ST_WRITE: state_nx = (wcur_q == wlast_q) ?
				cgmb_pkg::ST_DONE : cgmb_pkg::ST_READ;
			cgmb_pkg::ST_DONE:  if (can_out) state_nx = cgmb_pkg::ST_IDLE;
			default:            state_nx = cgmb_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wcur_q;
		ram_raddr = wcur_q;
		ram_wdata = '0;
		q_pop     = 1'b0;
		unique case (state_q)
			cgmb_pkg::ST_CLEAR: ram_we = 1'b1;
			cgmb_pkg::ST_IDLE:  q_pop  = q_valid;
			cgmb_pkg::ST_WRITE: begin
				if (op_q == cgmb_pkg::OP_MARK) begin
					ram_we    = 1'b1;
					ram_wdata = ram_rdata | mask;
				end else if (op_q == cgmb_pkg::OP_UNMARK) begin
					ram_we    = 1'b1;
					ram_wdata = ram_rdata & ~mask;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == cgmb_pkg::ST_IDLE && q_valid) begin
			op_q    <= q_op;
			wlast_q <= q_last[GB-1:BW];
			blo_q   <= q_first[BW-1:0];
			bhi_q   <= q_last[BW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= cgmb_pkg::ST_CLEAR;
			wcur_q       <= '0;
			first_word_q <= 1'b0;
			any_q        <= 1'b0;
			all_q        <= 1'b1;
			ovalid_q     <= 1'b0;
			hit_q        <= 1'b0;
			oerr_q       <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == cgmb_pkg::ST_DONE && can_out) ovalid_q <= 1'b1;
			else if (!out_stall) ovalid_q <= 1'b0;
			unique case (state_q)
				cgmb_pkg::ST_CLEAR: wcur_q <= wcur_q + WB'(1);
				cgmb_pkg::ST_IDLE: begin
					if (q_valid) begin
						wcur_q       <= q_first[GB-1:BW];
						first_word_q <= 1'b1;
						any_q        <= 1'b0;
						all_q        <= !q_empty_range;
					end
				end
				cgmb_pkg::ST_WRITE: begin
					if ((ram_rdata & mask) != '0) any_q <= 1'b1;
					if ((ram_rdata & mask) != mask) all_q <= 1'b0;
					wcur_q       <= wcur_q + WB'(1);
					first_word_q <= 1'b0;
				end
				cgmb_pkg::ST_DONE: begin
					if (can_out) begin
						hit_q    <= (op_q == cgmb_pkg::OP_ANY) ? any_q :
							(op_q == cgmb_pkg::OP_ALL) ? all_q : 1'b0;
						oerr_q   <= (op_q == cgmb_pkg::OP_MARK) && any_q;
					end
				end
				default: ;
			endcase
		end
	end

	assign out_valid     = ovalid_q;
	assign hit           = hit_q;
	assign overlap_error = oerr_q;

`ifndef NO_ASSERTIONS
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> state_q == cgmb_pkg::ST_IDLE) else $error("pop outside idle");
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(hit && overlap_error)) else $error("both flags set");
	a_no_write_query: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != cgmb_pkg::ST_CLEAR && (op_q == cgmb_pkg::OP_ANY ||
		op_q == cgmb_pkg::OP_ALL)) |-> !ram_we) else $error("query wrote bitmap");
`endif

endmodule

@@ test/tb_code_granule_mark_bitmap_unit.sv @@
// ----------------------------------------------------------------------------
// Testbench for the code granule mark bitmap unit
// Drives mark, unmark and query requests with random gaps and stalls, keeps
// its own granule bitmap to predict each result and compares every result
// transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_code_granule_mark_bitmap_unit;

	localparam int unsigned GRANULES =
		1 << (cgmb_pkg::ADDR_BITS_DEF - cgmb_pkg::GRAN_SHIFT_DEF);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [cgmb_pkg::OP_W-1:0] op = '0;
	logic [cgmb_pkg::ADDR_BITS_DEF-1:0] addr = '0;
	logic [cgmb_pkg::LEN_W-1:0] len = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic hit;
	logic overlap_error;

	typedef struct packed {
		logic hit;
		logic overlap_error;
	} verdict_t;

	bit granule_map [GRANULES];
	verdict_t verdict_queue [$];
	int error_count = 0;
	bit calm = 1'b0;

	code_granule_mark_bitmap_unit uut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.op(op), .addr(addr), .len(len), .out_valid(out_valid),
		.out_stall(out_stall), .hit(hit), .overlap_error(overlap_error)
	);

	always #5 clk = ~clk;

	function automatic verdict_t apply_range(cgmb_pkg::op_t o, logic [19:0] a,
		logic [12:0] l);
		verdict_t v;
		int unsigned n;
		int unsigned first;
		int unsigned last;
		int unsigned g;
		bit any_set;
		bit all_set;
		v = '0;
		n = (l > cgmb_pkg::MAX_LEN_DEF) ? cgmb_pkg::MAX_LEN_DEF : l;
		if (n == 0)
			return v;
		any_set = 1'b0;
		all_set = 1'b1;
		first = a >> cgmb_pkg::GRAN_SHIFT_DEF;
		last = (a + n - 1) >> cgmb_pkg::GRAN_SHIFT_DEF;
		for (int unsigned k = first; k <= last; k++) begin
			g = k % GRANULES;
			if (granule_map[g])
				any_set = 1'b1;
			else
				all_set = 1'b0;
			if (o == cgmb_pkg::OP_MARK)
				granule_map[g] = 1'b1;
			else if (o == cgmb_pkg::OP_UNMARK)
				granule_map[g] = 1'b0;
		end
		case (o)
			cgmb_pkg::OP_MARK: v.overlap_error = any_set;
			cgmb_pkg::OP_ANY: v.hit = any_set;
			cgmb_pkg::OP_ALL: v.hit = all_set;
			default: ;
		endcase
		return v;
	endfunction

	task automatic report(string what, logic got, logic want);
		$display("mismatch on %s: got %0b, expected %0b at %0t", what, got, want, $time);
		error_count++;
	endtask

	task automatic send_request(cgmb_pkg::op_t o, logic [19:0] a, logic [12:0] l);
		if (!calm)
			while ($urandom_range(99) < 11) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		in_valid <= 1'b1;
		op <= o;
		addr <= a;
		len <= l;
		verdict_queue.push_back(apply_range(o, a, l));
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (verdict_queue.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (verdict_queue.size() == 0) begin
				report("unexpected result transaction", 1'b1, 1'b0);
			end else begin
				want = verdict_queue.pop_front();
				if (hit !== want.hit)
					report("hit", hit, want.hit);
				if (overlap_error !== want.overlap_error)
					report("overlap_error", overlap_error, want.overlap_error);
			end
		end
		out_stall <= !calm && ($urandom_range(99) < 11);
	end

	task automatic test_directed();
		send_request(cgmb_pkg::OP_ANY, 20'd0, 13'd4096);
		send_request(cgmb_pkg::OP_ALL, 20'd0, 13'd0);
		send_request(cgmb_pkg::OP_MARK, 20'd0, 13'd1);
		send_request(cgmb_pkg::OP_MARK, 20'd2, 13'd4);
		send_request(cgmb_pkg::OP_ALL, 20'd0, 13'd8);
		send_request(cgmb_pkg::OP_ANY, 20'd8, 13'd8);
		send_request(cgmb_pkg::OP_MARK, 20'hFFFFE, 13'd8);
		send_request(cgmb_pkg::OP_ALL, 20'hFFFFC, 13'd8);
		send_request(cgmb_pkg::OP_MARK, 20'd4096, 13'h1FFF);
		send_request(cgmb_pkg::OP_ALL, 20'd4096, 13'd4096);
		send_request(cgmb_pkg::OP_UNMARK, 20'd4100, 13'd5000);
		send_request(cgmb_pkg::OP_ANY, 20'd4096, 13'd4096);
		send_request(cgmb_pkg::OP_MARK, 20'd3, 13'd0);
		send_request(cgmb_pkg::OP_UNMARK, 20'hFFFFF, 13'd4096);
		send_request(cgmb_pkg::OP_ANY, 20'h55555, 13'h0AAA);
		send_request(cgmb_pkg::OP_ALL, 20'hAAAAA, 13'h1555);
	endtask

	task automatic test_random(int count);
		logic [19:0] base;
		logic [12:0] l;
		for (int i = 0; i < count; i++) begin
			calm = (i >= count / 3) && (i < count / 2);
			base = ($urandom_range(3) == 0) ? 20'($urandom) : 20'($urandom_range(2047));
			case ($urandom_range(9))
				0: l = 13'($urandom);
				1: l = 13'($urandom_range(4096));
				default: l = 13'($urandom_range(64));
			endcase
			send_request(cgmb_pkg::op_t'($urandom_range(3)), base, l);
			if (i == count / 4)
				drain();
		end
		calm = 1'b0;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(1200);
		drain();
		repeat (60) @(posedge clk);
		if (error_count == 0 && verdict_queue.size() == 0)
			$display("tb_code_granule_mark_bitmap_unit: clean");
		else
			$display("tb_code_granule_mark_bitmap_unit: errors");
		$finish;
	end

	initial begin
		#5000000;
		$display("tb_code_granule_mark_bitmap_unit: errors");
		$finish;
	end

endmodule
